// File: rtl/core/sbpm_pkg.sv
// Shared constants and types for the streaming byte pattern matcher.
`default_nettype none

package sbpm_pkg;

	localparam int PATTERN_MAX  = 16;
	localparam int WINDOW_DEPTH = 16;
	localparam int LEN_W        = 5;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 64;
	localparam int BYTES_PER_REG = CFG_DATA_W / 8;

	localparam logic [LEN_W-1:0] LEN_SAT = '1;

	typedef logic [7:0] byte_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAT_LO  = 2'd0,
		CFG_PAT_HI  = 2'd1,
		CFG_PAT_LEN = 2'd2
	} cfg_idx_t;

	// per-cell control
	typedef struct packed {
		logic shift;   // take byte_in (the neighbor's byte, or the text byte at cell 0) this cycle
		logic in_use;  // cell lies inside the pattern span
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/sbpm_if.sv
// Valid/ready channel interfaces: text input, result output, config writes.
`default_nettype none

interface sbpm_in_if import sbpm_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  no_byte;
	logic  last_byte;

	modport source (output valid, output data_byte, output no_byte, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input no_byte, input last_byte,
		output ready);
endinterface

interface sbpm_out_if import sbpm_pkg::*; ();
	logic valid;
	logic ready;
	logic contains_match;
	logic ends_with_match;
	logic equals_match;

	modport source (output valid, output contains_match, output ends_with_match,
		output equals_match, input ready);
	modport sink (input valid, input contains_match, input ends_with_match,
		input equals_match, output ready);
endinterface

interface sbpm_cfg_if import sbpm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sbpm_cell.sv
// One window cell: holds a text byte, passes it on, compares against its pattern byte.
`default_nettype none

module sbpm_cell import sbpm_pkg::*; (
	input  wire logic      clk,
	input  wire cell_ctl_t ctl,
	input  wire byte_t     byte_in,
	input  wire byte_t     pat_byte,
	output      byte_t     byte_out,
	output      logic      hit
);

	byte_t byte_q;
	byte_t byte_nxt;

	assign byte_nxt = ctl.shift ? byte_in : byte_q;
	// compare on the post-shift value
	assign hit      = !ctl.in_use || (byte_nxt == pat_byte);
	assign byte_out = byte_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= byte_in;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/streaming_byte_pattern_matcher_core.sv
// Top level: streaming byte pattern matcher built as a chain of window cells.
//
//  channel | dir | payload                                          | moves on
//  --------+-----+--------------------------------------------------+-------------------
//  text    | in  | data_byte[7:0], no_byte, last_byte               | valid & ready
//  result  | out | contains_match, ends_with_match, equals_match    | valid & ready
//  cfg     | in  | index[1:0] (0 pat low, 1 pat high, 2 length),    | valid & ready
//          |     | data[63:0]                                       | (ready always 1)
//
// One text word per cycle, back to back. Each non-empty word shifts the 16-cell byte chain
// and the tail compare (16 byte compares plus an AND tree) settles in that same cycle.
// A result word appears the cycle after the last text word and sits in an output
// register; text stalls only while that register is full and result.ready is low.
// Reset (arst_n low) clears the config registers, length count, found flag and
// output valid; window bytes need no reset since the length count masks them.
`default_nettype none

module streaming_byte_pattern_matcher_core import sbpm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	sbpm_in_if.sink   text,
	sbpm_out_if.source result,
	sbpm_cfg_if.sink  cfg
);

	// config registers
	logic [CFG_DATA_W-1:0] pat_lo_q;
	logic [CFG_DATA_W-1:0] pat_hi_q;
	logic [LEN_W-1:0]      pat_len_q;

	// text state
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] len_nxt;
	logic             found_q;

	// output register
	logic out_valid_q;
	logic contains_q;
	logic ends_q;
	logic equals_q;

	logic text_fire;
	logic shift;
	logic len_ok;
	logic tail;
	logic contains_c;
	logic ends_c;
	logic equals_c;

	byte_t                   pat_arr   [PATTERN_MAX];
	byte_t                   cell_byte [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] cell_hit;

	assign cfg.ready  = 1'b1;
	assign text.ready = !out_valid_q || result.ready;
	assign text_fire  = text.valid && text.ready;
	assign shift      = text_fire && !text.no_byte;

	// unpack the pattern bytes, byte 0 in the low bits of the low register
	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pat
		if (j < BYTES_PER_REG) begin : g_lo
			assign pat_arr[j] = pat_lo_q[j*8 +: 8];
		end else begin : g_hi
			assign pat_arr[j] = pat_hi_q[(j-BYTES_PER_REG)*8 +: 8];
		end
	end

	// cell k holds the k-th newest byte and checks it against pattern byte len-1-k
	for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
		logic [LEN_W-1:0] pat_idx;
		cell_ctl_t        ctl;
		byte_t            byte_in;

		assign pat_idx    = pat_len_q - LEN_W'(k + 1);
		assign ctl.shift  = shift;
		assign ctl.in_use = LEN_W'(k) < pat_len_q;

		if (k == 0) begin : g_head
			assign byte_in = text.data_byte;
		end else begin : g_link
			assign byte_in = cell_byte[k-1];
		end

		sbpm_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.byte_in  (byte_in),
			.pat_byte (pat_arr[pat_idx[3:0]]),
			.byte_out (cell_byte[k]),
			.hit      (cell_hit[k])
		);
	end

	// saturating byte count after this word
	always_comb begin
		len_nxt = len_q;
		if (!text.no_byte && len_q != LEN_SAT) begin
			len_nxt = len_q + LEN_W'(1);
		end
	end

	assign len_ok = (pat_len_q != '0) && (pat_len_q <= LEN_W'(PATTERN_MAX));
	assign tail   = len_ok && (len_nxt >= pat_len_q) && (&cell_hit);

	// result flags; empty pattern: contains, ends, equals if no bytes; oversize: none
	always_comb begin
		if (pat_len_q == '0) begin
			contains_c = 1'b1;
			ends_c     = 1'b1;
			equals_c   = (len_nxt == '0);
		end else if (!len_ok) begin
			contains_c = 1'b0;
			ends_c     = 1'b0;
			equals_c   = 1'b0;
		end else begin
			contains_c = found_q || tail;
			ends_c     = tail;
			equals_c   = tail && (len_nxt == pat_len_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_idx_t'(cfg.index))
				CFG_PAT_LO:  pat_lo_q  <= cfg.data;
				CFG_PAT_HI:  pat_hi_q  <= cfg.data;
				CFG_PAT_LEN: pat_len_q <= cfg.data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			found_q <= 1'b0;
		end else if (text_fire) begin
			if (text.last_byte) begin
				len_q   <= '0;
				found_q <= 1'b0;
			end else begin
				len_q   <= len_nxt;
				found_q <= found_q || (shift && tail);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (text_fire && text.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_fire && text.last_byte) begin
			contains_q <= contains_c;
			ends_q     <= ends_c;
			equals_q   <= equals_c;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.contains_match  = contains_q;
	assign result.ends_with_match = ends_q;
	assign result.equals_match    = equals_q;

	// checks
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		text_fire && text.last_byte |=> out_valid_q)
		else $error("last word did not load a result");

	a_last_clears_state: assert property (@(posedge clk) disable iff (!arst_n)
		text_fire && text.last_byte |=> (len_q == '0) && !found_q)
		else $error("text state not cleared after last word");

	a_equals_implies_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && equals_q |-> ends_q && contains_q)
		else $error("equals flagged without ends/contains");

	a_mid_text_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		text_fire && !text.last_byte |=> out_valid_q == ($past(out_valid_q) && !$past(result.ready)))
		else $error("result produced by a non-last word");

endmodule

`default_nettype wire
